FILE: sv/ecr_pkg.sv
`timescale 1ns / 1ps
package ecr_pkg;

    localparam int ELEV_W    = 16;
    localparam int MAXE_W    = 15;
    localparam int CHAN_W    = 8;
    localparam int STOP_W    = 41;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 3;
    localparam int THR_LSB   = 24;
    localparam int THR_RAW_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
    localparam logic [THR_RAW_W-1:0] THR_RAW_ONE    = 17'h10000;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } color_t;

endpackage

FILE: sv/ecr_if.sv
`timescale 1ns / 1ps
interface ecr_sample_if;
    logic                               valid;
    logic                               ready;
    logic signed [ecr_pkg::ELEV_W-1:0]  elevation;
    logic        [ecr_pkg::MAXE_W-1:0]  max_elevation;

    modport source (output valid, output elevation, output max_elevation, input ready);
    modport sink   (input valid, input elevation, input max_elevation, output ready);
endinterface

interface ecr_color_if;
    logic                         valid;
    logic                         ready;
    logic [ecr_pkg::CHAN_W-1:0]   red;
    logic [ecr_pkg::CHAN_W-1:0]   green;
    logic [ecr_pkg::CHAN_W-1:0]   blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface ecr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ecr_pkg::CFG_IDX_W-1:0]   index;
    logic [ecr_pkg::STOP_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/elevation_color_ramp.sv
`timescale 1ns / 1ps
// Elevation color ramp: maps a signed elevation sample and a map maximum to an
// RGB color through a piecewise-linear gradient of up to MAX_STOPS stops.
// Channels (valid/ready, item moves when both are high):
//   sample : elevation and max_elevation in.
//   color  : red, green, blue out, one item per sample item, in order.
//   cfg    : register writes; index 0 is the stop count, 1..7 the stops
//            (threshold Q1.16 in bits 40:24, RGB in 23:0). Always ready.
// Throughput is one item per cycle while the receiver does not stall: the
// normalizing divide runs one quotient bit per stage (FRAC_BITS stages) and
// the interpolation divide another eight stages, all fully pipelined.
// Reset clears the pipeline, sets the stop count to one and all stops to zero.
// When the receiver stalls, the whole pipeline holds; sample.ready drops only
// while a finished color waits, and bubbles do not close up behind it.
// Write configuration only while the pipeline is empty.
module elevation_color_ramp #(
    parameter int MAX_STOPS = 7,
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    ecr_sample_if.sink  sample,
    ecr_color_if.source color,
    ecr_cfg_if.sink     cfg
);
    import ecr_pkg::*;

    localparam int FB   = FRAC_BITS;
    localparam int TW   = FB + 1;
    localparam int SW   = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int PW   = CHAN_W + TW;
    localparam int NW   = PW + 1;
    localparam int QB   = CHAN_W;
    localparam int LAT  = FB + 14;
    localparam int S_SEL = FB + 1;
    localparam int S_DIF = FB + 2;
    localparam int S_MUL = FB + 3;
    localparam int S_SUM = FB + 4;
    localparam int S_OUT = FB + 13;
    localparam logic [TW-1:0] ONE = TW'(1) << FB;

    function automatic logic [TW-1:0] thr_of(input logic [STOP_W-1:0] v);
        logic [THR_RAW_W-1:0] t;
        logic [STOP_W-1:0]    w;
        t = v[THR_LSB +: THR_RAW_W];
        if (t > THR_RAW_ONE)
            t = THR_RAW_ONE;
        w = {{(STOP_W-THR_RAW_W){1'b0}}, t};
        if (FB >= 16)
            w = w << ((FB >= 16) ? FB - 16 : 0);
        else
            w = w >> ((FB < 16) ? 16 - FB : 0);
        return w[TW-1:0];
    endfunction

    // configuration
    logic [CNT_W-1:0] count_reg;
    logic [TW-1:0]    thr_reg [MAX_STOPS];
    color_t           col_reg [MAX_STOPS];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(1);
            for (int i = 0; i < MAX_STOPS; i++)
            begin
                thr_reg[i] <= '0;
                col_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_STOP_COUNT)
                count_reg <= cfg.data[CNT_W-1:0];
            else
            begin
                for (int i = 0; i < MAX_STOPS; i++)
                begin
                    if (cfg.index == CFG_IDX_W'(i + 1))
                    begin
                        thr_reg[i] <= thr_of(cfg.data);
                        col_reg[i] <= cfg.data[3*CHAN_W-1:0];
                    end
                end
            end
        end
    end

    // pipeline control
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en           = !vld_reg[LAT-1] || color.ready;
    assign sample.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], sample.valid};
    end

    // entry and normalizing divide
    logic [MAXE_W-1:0] d1_r_reg   [FB+1];
    logic [MAXE_W-1:0] d1_d_reg   [FB+1];
    logic [FB-1:0]     d1_q_reg   [FB+1];
    logic              d1_neg_reg [FB+1];
    logic              d1_sat_reg [FB+1];
    logic [MAXE_W-1:0] max_eff;

    assign max_eff = (sample.max_elevation == '0) ? MAXE_W'(1) : sample.max_elevation;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_r_reg[0]   <= sample.elevation[MAXE_W-1:0];
            d1_d_reg[0]   <= max_eff;
            d1_q_reg[0]   <= '0;
            d1_neg_reg[0] <= sample.elevation[ELEV_W-1];
            d1_sat_reg[0] <= sample.elevation[MAXE_W-1:0] >= max_eff;
        end
    end

    for (genvar k = 0; k < FB; k++)
    begin : g_div1
        logic [MAXE_W:0] r2;
        logic            ge;
        assign r2 = {d1_r_reg[k], 1'b0};
        assign ge = r2 >= {1'b0, d1_d_reg[k]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d1_r_reg[k+1]   <= ge ? MAXE_W'(r2 - {1'b0, d1_d_reg[k]}) : r2[MAXE_W-1:0];
                d1_q_reg[k+1]   <= {d1_q_reg[k][FB-2:0], ge};
                d1_d_reg[k+1]   <= d1_d_reg[k];
                d1_neg_reg[k+1] <= d1_neg_reg[k];
                d1_sat_reg[k+1] <= d1_sat_reg[k];
            end
        end
    end

    // stop selection
    logic [TW-1:0]    f_w;
    logic [CNT_W-1:0] n_eff;
    logic [SW-1:0]    last_idx;
    logic [SW-1:0]    hi_idx;
    logic [SW-1:0]    lo_idx;
    logic             dir_w;
    color_t           dcol_w;

    always_comb
    begin
        if (d1_neg_reg[FB])
            f_w = '0;
        else if (d1_sat_reg[FB])
            f_w = ONE;
        else
            f_w = {1'b0, d1_q_reg[FB]};
        if (count_reg == '0)
            n_eff = CNT_W'(1);
        else if (count_reg > CNT_W'(MAX_STOPS))
            n_eff = CNT_W'(MAX_STOPS);
        else
            n_eff = count_reg;
        last_idx = SW'(n_eff - CNT_W'(1));
        hi_idx   = last_idx;
        for (int i = MAX_STOPS - 1; i >= 1; i--)
        begin
            if (CNT_W'(i) < n_eff && f_w <= thr_reg[i])
                hi_idx = SW'(i);
        end
        lo_idx = (hi_idx == '0) ? '0 : hi_idx - SW'(1);
        dir_w  = 1'b1;
        dcol_w = col_reg[0];
        if (f_w > thr_reg[0])
        begin
            if (f_w >= thr_reg[last_idx])
                dcol_w = col_reg[last_idx];
            else
                dir_w = 1'b0;
        end
    end

    logic [TW-1:0] sel_f_reg, sel_t1_reg, sel_t2_reg;
    color_t        sel_c1_reg, sel_c2_reg, sel_dcol_reg;
    logic          sel_dir_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_f_reg    <= f_w;
            sel_t1_reg   <= thr_reg[lo_idx];
            sel_t2_reg   <= thr_reg[hi_idx];
            sel_c1_reg   <= col_reg[lo_idx];
            sel_c2_reg   <= col_reg[hi_idx];
            sel_dcol_reg <= dcol_w;
            sel_dir_reg  <= dir_w;
        end
    end

    // weights and span
    logic [TW-1:0] dif_a_reg, dif_b_reg, dif_span_reg;
    color_t        dif_c1_reg, dif_c2_reg, dif_dcol_reg;
    logic          dif_dir_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dif_a_reg    <= sel_t2_reg - sel_f_reg;
            dif_b_reg    <= sel_f_reg - sel_t1_reg;
            dif_span_reg <= sel_t2_reg - sel_t1_reg;
            dif_c1_reg   <= sel_c1_reg;
            dif_c2_reg   <= sel_c2_reg;
            dif_dcol_reg <= sel_dcol_reg;
            dif_dir_reg  <= sel_dir_reg;
        end
    end

    // products, then sums
    logic [PW-1:0] mul_p1_reg [3];
    logic [PW-1:0] mul_p2_reg [3];
    logic [TW-1:0] mul_span_reg;
    color_t        mul_dcol_reg;
    logic          mul_dir_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_p1_reg[0] <= PW'(dif_c1_reg.red   * dif_a_reg);
            mul_p1_reg[1] <= PW'(dif_c1_reg.green * dif_a_reg);
            mul_p1_reg[2] <= PW'(dif_c1_reg.blue  * dif_a_reg);
            mul_p2_reg[0] <= PW'(dif_c2_reg.red   * dif_b_reg);
            mul_p2_reg[1] <= PW'(dif_c2_reg.green * dif_b_reg);
            mul_p2_reg[2] <= PW'(dif_c2_reg.blue  * dif_b_reg);
            mul_span_reg  <= dif_span_reg;
            mul_dcol_reg  <= dif_dcol_reg;
            mul_dir_reg   <= dif_dir_reg;
        end
    end

    // interpolation divide, index 0 holds the sums
    logic [NW-1:0] d2_r_reg    [QB+1][3];
    logic [QB-1:0] d2_q_reg    [QB+1][3];
    logic [TW-1:0] d2_span_reg [QB+1];
    color_t        d2_dcol_reg [QB+1];
    logic          d2_dir_reg  [QB+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                d2_r_reg[0][c] <= {1'b0, mul_p1_reg[c]} + {1'b0, mul_p2_reg[c]};
                d2_q_reg[0][c] <= '0;
            end
            d2_span_reg[0] <= mul_span_reg;
            d2_dcol_reg[0] <= mul_dcol_reg;
            d2_dir_reg[0]  <= mul_dir_reg;
        end
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_div2
        logic [NW-1:0] dsh;
        assign dsh = {{(NW-TW){1'b0}}, d2_span_reg[j]} << (QB - 1 - j);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (d2_r_reg[j][c] >= dsh)
                    begin
                        d2_r_reg[j+1][c] <= d2_r_reg[j][c] - dsh;
                        d2_q_reg[j+1][c] <= {d2_q_reg[j][c][QB-2:0], 1'b1};
                    end
                    else
                    begin
                        d2_r_reg[j+1][c] <= d2_r_reg[j][c];
                        d2_q_reg[j+1][c] <= {d2_q_reg[j][c][QB-2:0], 1'b0};
                    end
                end
                d2_span_reg[j+1] <= d2_span_reg[j];
                d2_dcol_reg[j+1] <= d2_dcol_reg[j];
                d2_dir_reg[j+1]  <= d2_dir_reg[j];
            end
        end
    end

    // output register
    color_t out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (d2_dir_reg[QB])
                out_reg <= d2_dcol_reg[QB];
            else
                out_reg <= {d2_q_reg[QB][0], d2_q_reg[QB][1], d2_q_reg[QB][2]};
        end
    end

    assign color.valid = vld_reg[S_OUT];
    assign color.red   = out_reg.red;
    assign color.green = out_reg.green;
    assign color.blue  = out_reg.blue;

`ifndef ASSERT_OFF
    a_interp_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_SEL] && !sel_dir_reg |->
            sel_t1_reg < sel_f_reg && sel_f_reg <= sel_t2_reg)
        else $error("interpolation stops do not bracket the fraction");
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_SEL] |-> sel_f_reg <= ONE)
        else $error("fraction above one");
    a_span_pos: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_MUL] && !mul_dir_reg |-> mul_span_reg != '0)
        else $error("zero span in interpolation");
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> color.valid && !color.ready)
        else $error("input stalled without a waiting result");
    a_sum_track: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[S_DIF] |=> vld_reg[S_MUL])
        else $error("valid lost between stages");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import ecr_pkg::*;

    localparam int NUM_STOPS = 7;
    localparam int FRAC      = 16;
    localparam int LATENCY   = FRAC + 14;
    localparam int IDLE_LIMIT = 20000;

    // Configuration register indexes; stop k has index STOP_BASE + k.
    localparam logic [CFG_IDX_W-1:0] STOP_BASE = 3'd1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    ecr_sample_if sample_ch();
    ecr_color_if  color_ch();
    ecr_cfg_if    cfg_ch();

    elevation_color_ramp #(.MAX_STOPS(NUM_STOPS), .FRAC_BITS(FRAC)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch.sink),
        .color  (color_ch.source),
        .cfg    (cfg_ch.sink)
    );

    class color_scoreboard;
        logic [CNT_W-1:0]  stop_count;
        logic [STOP_W-1:0] stops [NUM_STOPS];
        color_t            pending_colors [$];
        int                errors;

        function void clear_ramp();
            stop_count = CNT_W'(1);
            foreach (stops[i]) stops[i] = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [STOP_W-1:0] value);
            if (idx == REG_STOP_COUNT)
                stop_count = value[CNT_W-1:0];
            else if (idx <= NUM_STOPS)
                stops[idx - STOP_BASE] = value;
        endfunction

        function longint unsigned threshold(logic [STOP_W-1:0] s);
            longint unsigned t;
            t = s[STOP_W-1:THR_LSB];
            if (t > THR_RAW_ONE) t = THR_RAW_ONE;
            return t << (FRAC - 16);
        endfunction

        function logic [7:0] chan(logic [STOP_W-1:0] s, int k);
            return s[23 - 8*k -: 8];
        endfunction

        function color_t ramp_color(logic signed [ELEV_W-1:0] elev,
                                    logic [MAXE_W-1:0] maxe);
            longint unsigned f, n, t1, t2, span, c1, c2;
            logic [STOP_W-1:0] lo, hi;
            logic [7:0] ch [3];
            color_t c;
            f = 0;
            n = stop_count;
            if (maxe == 0) maxe = MAXE_W'(1);
            if (elev < 0)
                f = 0;
            else if (elev >= $signed({1'b0, maxe}))
                f = longint'(1) << FRAC;
            else
                f = (longint'(elev) << FRAC) / maxe;
            if (n == 0) n = 1;
            if (n > NUM_STOPS) n = NUM_STOPS;
            if (f <= threshold(stops[0])) begin
                lo = stops[0];
                hi = stops[0];
            end else if (f >= threshold(stops[n-1])) begin
                lo = stops[n-1];
                hi = stops[n-1];
            end else begin
                lo = stops[n-2];
                hi = stops[n-1];
                for (int i = 1; i < n; i++) begin
                    if (f <= threshold(stops[i])) begin
                        lo = stops[i-1];
                        hi = stops[i];
                        break;
                    end
                end
            end
            t1 = threshold(lo);
            t2 = threshold(hi);
            span = (t2 > t1) ? t2 - t1 : 0;
            for (int k = 0; k < 3; k++) begin
                c1 = chan(lo, k);
                c2 = chan(hi, k);
                if (span == 0 || f < t1 || f > t2)
                    ch[k] = 8'(c2);
                else
                    ch[k] = 8'((c1 * (t2 - f) + c2 * (f - t1)) / span);
            end
            c.red = ch[0];
            c.green = ch[1];
            c.blue = ch[2];
            return c;
        endfunction

        function void note_sample(logic signed [ELEV_W-1:0] elev, logic [MAXE_W-1:0] maxe);
            pending_colors = {pending_colors, ramp_color(elev, maxe)};
        endfunction

        function void check_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            color_t want;
            if (pending_colors.size() == 0) begin
                $error("color item with no sample pending");
                errors++;
                return;
            end
            want = pending_colors.pop_front();
            if (r !== want.red) begin
                $error("red: expected %0d, got %0d", want.red, r);
                errors++;
            end
            if (g !== want.green) begin
                $error("green: expected %0d, got %0d", want.green, g);
                errors++;
            end
            if (b !== want.blue) begin
                $error("blue: expected %0d, got %0d", want.blue, b);
                errors++;
            end
        endfunction
    endclass

    color_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  idle_cycles;

    initial begin
        sb = new();
        sb.clear_ramp();
    end

    always @(posedge clk) begin
        if (sample_ch.valid && sample_ch.ready)
            sb.note_sample(sample_ch.elevation, sample_ch.max_elevation);
        if (color_ch.valid && color_ch.ready)
            sb.check_color(color_ch.red, color_ch.green, color_ch.blue);
    end

    // Receiver: random stalls, or a long hold when asked.
    always @(negedge clk) begin
        if (!rst_n || recv_hold)
            color_ch.ready <= 1'b0;
        else
            color_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: count cycles in which nothing moves.
    always @(posedge clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (color_ch.valid && color_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_sample(logic signed [ELEV_W-1:0] elev, logic [MAXE_W-1:0] maxe);
        while ($urandom_range(99) < send_idle_pct) begin
            sample_ch.valid = 1'b0;
            @(negedge clk);
        end
        sample_ch.valid = 1'b1;
        sample_ch.elevation = elev;
        sample_ch.max_elevation = maxe;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        @(negedge clk);
        sample_ch.valid = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STOP_W-1:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_colors.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [STOP_W-1:0] pack_stop(int thr, logic [23:0] rgb);
        logic [STOP_W-1:0] s;
        s = '0;
        s[STOP_W-1:THR_LSB] = THR_RAW_W'(thr);
        s[23:0] = rgb;
        return s;
    endfunction

    // Load an ascending ramp of n stops, or a scrambled one when asked.
    task automatic load_ramp(int n, bit scramble);
        int thr;
        int step;
        write_reg(REG_STOP_COUNT, STOP_W'(n));
        thr = $urandom_range(0, 16'h4000);
        for (int i = 0; i < NUM_STOPS; i++) begin
            step = $urandom_range(0, 16'h8000 / ((n == 0) ? 1 : n));
            thr = scramble ? $urandom_range(0, 17'h1FFFF) : thr + step;
            if (thr > 17'h1FFFF) thr = 17'h1FFFF;
            write_reg(CFG_IDX_W'(int'(STOP_BASE) + i), pack_stop(thr, 24'($urandom())));
        end
    endtask

    function automatic logic signed [ELEV_W-1:0] rand_elev(logic [MAXE_W-1:0] maxe);
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return ELEV_W'($urandom());
        if (pick == 1) return -$signed({1'b0, 15'($urandom())});
        if (pick == 2) return ELEV_W'(int'(maxe) + $urandom_range(0, 50));
        return ELEV_W'($urandom_range(0, maxe));
    endfunction

    task automatic random_batch(int count);
        logic [MAXE_W-1:0] maxe;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0:       maxe = MAXE_W'($urandom_range(0, 20));
                1:       maxe = 15'h7FFF;
                default: maxe = MAXE_W'($urandom());
            endcase
            send_sample(rand_elev(maxe), maxe);
        end
    endtask

    initial begin
        sample_ch.valid = 1'b0;
        sample_ch.elevation = '0;
        sample_ch.max_elevation = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        color_ch.ready = 1'b0;
        recv_hold = 1'b0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset ramp: single black stop.
        send_sample(16'sd100, 15'd200);
        send_sample(-16'sd1, 15'd0);
        drain();

        // Directed ramp with a threshold above one and equal thresholds.
        write_reg(REG_STOP_COUNT, 3'd4);
        write_reg(STOP_BASE + 0, pack_stop(17'h04000, 24'hFF0000));
        write_reg(STOP_BASE + 1, pack_stop(17'h08000, 24'h00FF00));
        write_reg(STOP_BASE + 2, pack_stop(17'h08000, 24'h0000FF));
        write_reg(STOP_BASE + 3, pack_stop(17'h1FFFF, 24'hFFFFFF));
        write_reg(STOP_BASE + 4, pack_stop(17'h00000, 24'h123456));
        write_reg(STOP_BASE + 5, pack_stop(17'h1FFFF, 24'hABCDEF));
        write_reg(STOP_BASE + 6, pack_stop(17'h10000, 24'h0F0F0F));
        send_sample(16'sh7FFF, 15'h7FFF);
        send_sample(-16'sh8000, 15'h7FFF);
        send_sample(16'sd0, 15'd0);
        send_sample(16'sd5, 15'd0);
        send_sample(16'sh7FFF, 15'd1);
        send_sample(16'sd3, 15'd10);
        send_sample(16'sd5, 15'd10);
        send_sample(16'sd7, 15'd10);
        send_sample(16'sd1, 15'd4);
        send_sample(16'sd9999, 15'h7FFF);
        send_sample(16'sh5555, 15'h2AAA);
        drain();
        // Zero count and the full count.
        write_reg(REG_STOP_COUNT, 3'd0);
        send_sample(16'sd7, 15'd10);
        drain();
        write_reg(REG_STOP_COUNT, 3'd7);
        send_sample(16'sd7, 15'd10);
        send_sample(16'sd1, 15'd2);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 56 : 0;
            recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 14 : 0;
            for (int r = 0; r < 8; r++) begin
                load_ramp((r == 0) ? 1 : (r == 1) ? 7 : $urandom_range(0, 7), r == 7);
                if (phase == 2 && r == 3) begin
                    fork
                        begin
                            recv_hold = 1'b1;
                            repeat (200) @(negedge clk);
                            recv_hold = 1'b0;
                        end
                        random_batch(80);
                    join
                end else
                    random_batch(80);
                drain();
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending_colors.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
